// ----- rtl/lpd_pkg.sv -----
// Package for the length-prefixed deframer: header sizes, result type and
// the byte-insert helper. No dependencies.
`default_nettype none

package lpd_pkg;

  // Header layout: kind bytes first, then length bytes, little-endian
  localparam int unsigned KindBytes   = 4;
  localparam int unsigned LengthBytes = 4;
  localparam int unsigned HdrBytes    = KindBytes + LengthBytes;

  // One result beat
  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [31:0] body_offset;
    logic [31:0] message_kind;
    logic [31:0] message_length;
    logic        message_end;
  } lpd_result_t;

  // Place byte b at little-endian byte position pos of a 32-bit word
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [1:0]  pos,
                                           input logic [7:0]  b);
    logic [31:0] res;
    res = word;
    res[8*pos +: 8] = b;
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/length_prefixed_deframer.sv -----
// Length-prefixed message deframer, top level: input register, deframing
// core and result register. Depends on lpd_pkg and lpd_core.
//
// Usage:
//   Input channel: one stream byte per beat on stream_byte_i, with
//   in_valid_i / in_ready_o. Output channel: one result beat per input
//   beat, with out_valid_o / out_ready_i. Each message is a 4-byte kind and
//   a 4-byte length (little-endian, kind first), then length body bytes.
//   Body bytes come out with body_valid_o, their offset and the message's
//   kind and length; message_end_o marks the byte that completes a message
//   (the last header byte for a zero-length message).
//   Path: an accepted byte is held in the input register, then moves into
//   the result register, where its result is presented. Throughput: one
//   byte per cycle while the receiver keeps out_ready_i high; the deframing
//   core updates its state once per byte.
//   Stall: while the receiver holds out_ready_i low, one more byte is
//   taken into the input register, then in_ready_o drops until the result
//   register drains.
//   Reset: both registers empty, the core expects the first header byte.
`default_nettype none

module length_prefixed_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  stream_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        body_valid_o,
  output      logic [7:0]  body_byte_o,
  output      logic [31:0] body_offset_o,
  output      logic [31:0] message_kind_o,
  output      logic [31:0] message_length_o,
  output      logic        message_end_o
);
  import lpd_pkg::*;

  logic        in_full_q;
  logic [7:0]  in_byte_q;
  logic        out_full_q;
  lpd_result_t out_q;
  lpd_result_t core_result;
  logic        advance;

  // Input register moves into the result register when that slot is free
  assign advance    = in_full_q && (!out_full_q || out_ready_i);
  assign in_ready_o = !in_full_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_ready_o) begin
      in_full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= stream_byte_i;
    end
  end

  lpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (core_result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (advance) begin
      out_full_q <= 1'b1;
    end else if (out_ready_i) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_result;
    end
  end

  assign out_valid_o      = out_full_q;
  assign body_valid_o     = out_q.body_valid;
  assign body_byte_o      = out_q.body_byte;
  assign body_offset_o    = out_q.body_offset;
  assign message_kind_o   = out_q.message_kind;
  assign message_length_o = out_q.message_length;
  assign message_end_o    = out_q.message_end;

endmodule

`default_nettype wire

// ----- rtl/lpd_core.sv -----
// Deframing state: header gathering, body counting and result generation.
// Depends on lpd_pkg.
`default_nettype none

module lpd_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output lpd_pkg::lpd_result_t     result_o
);
  import lpd_pkg::*;

  logic        in_body_q, in_body_d;
  logic [31:0] count_q, count_d;
  logic [31:0] kind_q, kind_d;
  logic [31:0] length_q, length_d;
  logic [31:0] kind_base, length_base;
  logic [32:0] count_inc;

  assign count_inc = {1'b0, count_q} + 33'd1;

  // Next state and result for the byte at hand
  always_comb begin
    in_body_d   = in_body_q;
    count_d     = count_inc[31:0];
    kind_d      = kind_q;
    length_d    = length_q;
    kind_base   = kind_q;
    length_base = length_q;
    result_o    = '0;
    if (!in_body_q) begin
      // First header byte clears both fields
      if (count_q == 32'd0) begin
        kind_base   = '0;
        length_base = '0;
      end
      kind_d   = kind_base;
      length_d = length_base;
      if (count_q < 32'(KindBytes)) begin
        kind_d = put_byte(kind_base, count_q[1:0], byte_i);
      end else begin
        length_d = put_byte(length_base, 2'(count_q - 32'(KindBytes)), byte_i);
      end
      if (count_inc >= 33'(HdrBytes)) begin
        count_d                 = '0;
        result_o.message_kind   = kind_d;
        result_o.message_length = length_d;
        if (length_d == 32'd0) begin
          result_o.message_end = 1'b1;
        end else begin
          in_body_d = 1'b1;
        end
      end
    end else begin
      result_o.body_valid     = 1'b1;
      result_o.body_byte      = byte_i;
      result_o.body_offset    = count_q;
      result_o.message_kind   = kind_q;
      result_o.message_length = length_q;
      if (count_inc >= {1'b0, length_q}) begin
        result_o.message_end = 1'b1;
        in_body_d            = 1'b0;
        count_d              = '0;
      end
    end
  end

  // State registers, advanced once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      count_q   <= '0;
      kind_q    <= '0;
      length_q  <= '0;
    end else if (step_i) begin
      in_body_q <= in_body_d;
      count_q   <= count_d;
      kind_q    <= kind_d;
      length_q  <= length_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpd_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
// Depends on length_prefixed_deframer.
`default_nettype none

module lpd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        body_valid_o,
  input wire logic [7:0]  body_byte_o,
  input wire logic [31:0] body_offset_o,
  input wire logic [31:0] message_length_o,
  input wire logic        message_end_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(body_offset_o)
      && $stable(message_end_o) && $stable(body_valid_o)))
    else $error("stalled result beat changed");

  // Header beats carry no body byte or offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !body_valid_o) |-> (body_byte_o == 8'd0 && body_offset_o == 32'd0))
    else $error("header beat with body data");

  // Last body byte sits at offset length - 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && body_valid_o && message_end_o)
      |-> (body_offset_o + 32'd1 == message_length_o))
    else $error("message end at wrong body offset");

  // A message ending on its header has zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !body_valid_o && message_end_o) |-> (message_length_o == 32'd0))
    else $error("header end with nonzero length");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .body_valid_o     (body_valid_o),
  .body_byte_o      (body_byte_o),
  .body_offset_o    (body_offset_o),
  .message_length_o (message_length_o),
  .message_end_o    (message_end_o)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for length_prefixed_deframer: a queue-fed byte driver,
// a result monitor and a byte-level deframing predictor.
// Depends on lpd_pkg and the length_prefixed_deframer RTL.
module tb;
  import lpd_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned MaxReported   = 10;

  // Flow-control phases: sender-light/receiver-heavy, swapped, then none
  localparam int unsigned PhaseRecvStall = 0;
  localparam int unsigned PhaseSendIdle  = 1;
  localparam int unsigned PhaseNoIdle    = 2;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  stream_byte   = 8'h00;
  logic        out_ready     = 1'b0;
  logic        in_ready;
  logic        out_valid;
  lpd_result_t dut_res;

  // Stimulus and expectations
  logic [7:0]  stream_q[$];
  lpd_result_t pending_results[$];
  int unsigned total_bytes;
  int unsigned bytes_in;
  int unsigned beats_out;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // Predictor state
  logic        in_body_q;
  logic [31:0] taken_cnt;
  logic [31:0] kind_acc;
  logic [31:0] len_acc;
  int unsigned msgs_done;
  int unsigned empty_msgs;
  int unsigned body_bytes;

  length_prefixed_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .stream_byte_i    (stream_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .body_valid_o     (dut_res.body_valid),
    .body_byte_o      (dut_res.body_byte),
    .body_offset_o    (dut_res.body_offset),
    .message_kind_o   (dut_res.message_kind),
    .message_length_o (dut_res.message_length),
    .message_end_o    (dut_res.message_end)
  );

  always #5 clk_i = ~clk_i;

  // Deframing predictor: one result per stream byte
  function automatic lpd_result_t deframe_byte(input logic [7:0] b);
    lpd_result_t r;
    logic [31:0] pos;
    r = '0;
    if (!in_body_q) begin
      // header bytes: kind then length, little-endian
      if (taken_cnt == 0) begin
        kind_acc = '0;
        len_acc  = '0;
      end
      if (taken_cnt < KindBytes) begin
        if (taken_cnt < 4) kind_acc[8*taken_cnt[1:0] +: 8] = b;
      end else begin
        pos = taken_cnt - KindBytes;
        if (pos < 4) len_acc[8*pos[1:0] +: 8] = b;
      end
      taken_cnt++;
      if (taken_cnt >= HdrBytes) begin
        taken_cnt        = '0;
        r.message_kind   = kind_acc;
        r.message_length = len_acc;
        if (len_acc == 0) begin
          r.message_end = 1'b1;
          msgs_done++;
          empty_msgs++;
        end else begin
          in_body_q = 1'b1;
        end
      end
    end else begin
      // body byte with its offset
      r.body_valid     = 1'b1;
      r.body_byte      = b;
      r.body_offset    = taken_cnt;
      r.message_kind   = kind_acc;
      r.message_length = len_acc;
      body_bytes++;
      taken_cnt++;
      if (taken_cnt >= len_acc) begin
        r.message_end = 1'b1;
        in_body_q     = 1'b0;
        taken_cnt     = '0;
        msgs_done++;
      end
    end
    return r;
  endfunction

  function automatic int unsigned current_phase();
    if (bytes_in < total_bytes / 3) return PhaseRecvStall;
    if (bytes_in < (2 * total_bytes) / 3) return PhaseSendIdle;
    return PhaseNoIdle;
  endfunction

  // Append one byte to the stimulus stream
  task automatic queue_byte(input logic [7:0] b);
    stream_q = {stream_q, b};
  endtask

  task automatic queue_header(input logic [31:0] kind, input logic [31:0] len);
    for (int i = 0; i < KindBytes; i++) queue_byte(kind[8*i +: 8]);
    for (int i = 0; i < LengthBytes; i++) queue_byte(len[8*i +: 8]);
  endtask

  // Driver: presents the next byte when the slot is free, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned idle_pct;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      stream_byte <= 8'h00;
      in_body_q   = 1'b0;
      taken_cnt   = '0;
      kind_acc    = '0;
      len_acc     = '0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results = {pending_results, deframe_byte(stream_byte)};
        bytes_in++;
      end
      if (!in_valid || in_ready) begin
        case (current_phase())
          PhaseRecvStall: idle_pct = 10;
          PhaseSendIdle:  idle_pct = 46;
          default:        idle_pct = 0;
        endcase
        if (stream_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid    <= 1'b1;
          stream_byte <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall_pct;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      case (current_phase())
        PhaseRecvStall: stall_pct = 46;
        PhaseSendIdle:  stall_pct = 10;
        default:        stall_pct = 0;
      endcase
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    lpd_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        if (mismatches < MaxReported)
          $display("ERROR: unexpected result beat %0d at %0t", beats_out, $realtime);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want !== dut_res) begin
          if (mismatches < MaxReported) begin
            $display("ERROR: beat %0d at %0t", beats_out, $realtime);
            $display("  body_valid exp %0b got %0b, body_byte exp %02h got %02h",
                     want.body_valid, dut_res.body_valid,
                     want.body_byte, dut_res.body_byte);
            $display("  body_offset exp %0d got %0d, message_end exp %0b got %0b",
                     want.body_offset, dut_res.body_offset,
                     want.message_end, dut_res.message_end);
            $display("  kind exp %08h got %08h, length exp %08h got %08h",
                     want.message_kind, dut_res.message_kind,
                     want.message_length, dut_res.message_length);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("ERROR: timeout, no beat for %0d cycles", idle_cycles);
      $display("** length_prefixed_deframer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] len;
    int unsigned pick;
    bytes_in    = 0;
    beats_out   = 0;
    mismatches  = 0;
    idle_cycles = 0;
    msgs_done   = 0;
    empty_msgs  = 0;
    body_bytes  = 0;

    // Directed: empty body with all-ones kind, all-zero kind with extreme body
    // bytes, then a mixed-bit kind with a one-byte body
    queue_header(32'hFFFF_FFFF, 32'd0);
    queue_header(32'h0000_0000, 32'd2);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_header(32'hA55A_01FE, 32'd1);
    queue_byte(8'h80);

    // Random well-formed messages, mostly short bodies, some empty
    while (stream_q.size() < 1000) begin
      pick = $urandom_range(99);
      if (pick < 15)      len = 0;
      else if (pick < 85) len = $urandom_range(12, 1);
      else                len = $urandom_range(60, 13);
      queue_header($urandom, len);
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(255)));
    end

    // Noise tail: random header (usually a huge length) and a partial body
    for (int i = 0; i < 48; i++) queue_byte(8'($urandom_range(255)));
    total_bytes = stream_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Covered %0d stream bytes: %0d complete messages (%0d with empty body),",
             bytes_in, msgs_done, empty_msgs);
    $display("%0d body bytes, under three flow-control mixes; %0d mismatching beats.",
             body_bytes, mismatches);
    if (mismatches == 0) begin
      $display("** length_prefixed_deframer: PASSED **");
    end else begin
      $display("** length_prefixed_deframer: FAILED **");
    end
    $finish;
  end

endmodule
